>>> design/b64enc_pkg.sv
// shared types, constants and the sextet-to-ascii mapping of the base64 encoder
`default_nettype none

package b64enc_pkg;

  localparam int unsigned CharW = 7;
  localparam int unsigned CharsPerEntry = 4;

  localparam logic [CharW-1:0] PadChar = 7'h3d;

  // one accepted byte worth of characters, in output order
  typedef struct packed {
    logic [CharsPerEntry-1:0][CharW-1:0] chars;
    logic [1:0]                          last_idx;
    logic                                eom;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h47 + {1'b0, v};
    end else if (v < 6'd62) begin
      c = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      c = 7'h2b;
    end else begin
      c = 7'h2f;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/b64enc_front.sv
// front end: takes bytes, tracks the group position and builds the characters of each byte
`default_nettype none

module b64enc_front import b64enc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_message_i,
  input  wire queue_status_t q_status_i,
  output logic               push_o,
  output entry_t             entry_o
);

  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;

  logic [1:0] pos_q, pos_d;
  logic [3:0] carry_q, carry_d;
  logic       xfer;

  assign in_stall_o = q_status_i.full;
  assign xfer       = in_valid_i && !q_status_i.full;
  assign push_o     = xfer;

  always_comb begin
    entry_o.chars    = '0;
    entry_o.last_idx = 2'd0;
    entry_o.eom      = end_of_message_i;
    pos_d            = PosFirst;
    carry_d          = 4'd0;
    unique case (pos_q)
      PosSecond: begin
        entry_o.chars[0] = sextet_char({carry_q[1:0], data_byte_i[7:4]});
        if (end_of_message_i) begin
          entry_o.chars[1] = sextet_char({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = PadChar;
          entry_o.last_idx = 2'd2;
        end else begin
          pos_d   = PosThird;
          carry_d = data_byte_i[3:0];
        end
      end
      PosThird: begin
        entry_o.chars[0] = sextet_char({carry_q, data_byte_i[7:6]});
        entry_o.chars[1] = sextet_char(data_byte_i[5:0]);
        entry_o.last_idx = 2'd1;
      end
      default: begin
        // first byte of a group, also the unused position code
        entry_o.chars[0] = sextet_char(data_byte_i[7:2]);
        if (end_of_message_i) begin
          entry_o.chars[1] = sextet_char({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = PadChar;
          entry_o.chars[3] = PadChar;
          entry_o.last_idx = 2'd3;
        end else begin
          pos_d   = PosSecond;
          carry_d = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosFirst;
      carry_q <= 4'd0;
    end else if (xfer) begin
      pos_q   <= pos_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

>>> design/b64enc_queue.sv
// short queue of character groups between front and back end
`default_nettype none

module b64enc_queue import b64enc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      entry_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_wr, do_rd;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(Depth));
  assign do_wr          = push_i && !status_o.full;
  assign do_rd          = pop_i && !status_o.empty;
  assign entry_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/b64enc_back.sv
// back end: walks each queued group one character per unstalled cycle into the output register
`default_nettype none

module b64enc_back import b64enc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire entry_t        entry_i,
  input  wire queue_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [CharW-1:0]   out_char_o,
  output logic               last_char_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             load;
  logic             at_end;

  // output register can take a new character when empty or being drained
  assign load   = (!valid_q || !out_stall_i) && !q_status_i.empty;
  assign at_end = (idx_q == entry_i.last_idx);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= entry_i.chars[idx_q];
      last_q <= entry_i.eom && at_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

>>> design/base64_stream_encoder.sv
// top level of the streaming base64 encoder
`default_nettype none

// Streaming base64 encoder (standard alphabet, '=' padding). One message byte is
// taken per transfer, with end_of_message_i marking the last byte; characters leave
// as 7-bit ascii codes, one per transfer, and last_char_o marks the final character.
// A byte can be taken every cycle while the group queue (QueueDepth entries) has
// room. Output is one character per cycle while out_stall_i is low, through a
// single output register, so the sustained rate is set by the characters per byte:
// one for the first and second byte of a group, two for the third, and up to four
// for the last byte of a message. A byte's first character reaches the output by
// way of its queue entry and then the output register when the path is empty.
module base64_stream_encoder import b64enc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             end_of_message_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [CharW-1:0]      out_char_o,
  output logic                  last_char_o
);

  queue_status_t q_status;
  entry_t        push_entry, head_entry;
  logic          push, pop;

  b64enc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

`default_nettype wire

>>> design/b64enc_checker.sv
// port-level checker for the base64 encoder and its bind
`default_nettype none

module b64enc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       end_of_message_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [6:0] out_char_o,
  input wire logic       last_char_o
);

  logic       in_xfer, out_xfer;
  logic [7:0] eom_cnt_q;
  logic       pad_pending_q;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // messages whose last byte went in but whose last character has not come out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eom_cnt_q     <= 8'd0;
      pad_pending_q <= 1'b0;
    end else begin
      if ((in_xfer && end_of_message_i) && !(out_xfer && last_char_o)) begin
        eom_cnt_q <= eom_cnt_q + 8'd1;
      end else if (!(in_xfer && end_of_message_i) && (out_xfer && last_char_o)) begin
        eom_cnt_q <= eom_cnt_q - 8'd1;
      end
      if (out_xfer) begin
        pad_pending_q <= (out_char_o == 7'h3d) && !last_char_o;
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o) && $stable(last_char_o))
    else $error("stalled output changed");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o >= 7'h41 && out_char_o <= 7'h5a) ||
                    (out_char_o >= 7'h61 && out_char_o <= 7'h7a) ||
                    (out_char_o >= 7'h30 && out_char_o <= 7'h39) ||
                    out_char_o == 7'h2b || out_char_o == 7'h2f || out_char_o == 7'h3d)
    else $error("character outside the base64 set");

  a_pad_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && pad_pending_q |-> out_char_o == 7'h3d && last_char_o)
    else $error("padding not closed by a final pad");

  a_last_has_eom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && last_char_o |-> eom_cnt_q != 8'd0)
    else $error("final character without a final byte");

endmodule

bind base64_stream_encoder b64enc_checker u_b64enc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .end_of_message_i (end_of_message_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_char_o       (out_char_o),
  .last_char_o      (last_char_o)
);

`default_nettype wire
